FILE: src/segment_axis_plane_intersect_macros.svh
// Assertion helpers used by the checker file.
`ifndef SEGMENT_AXIS_PLANE_INTERSECT_MACROS_SVH
`define SEGMENT_AXIS_PLANE_INTERSECT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SAPI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SAPI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sapi_pkg.sv
package sapi_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int T_FRAC_BITS = 24;
	// delta width: difference of two coordinates
	localparam int DW = COORD_WIDTH + 1;
	// |d| * t product width
	localparam int PW = DW + T_FRAC_BITS + 1;

	localparam int CFG_W = 16;
	localparam logic [CFG_W-1:0] MIN_DELTA_RESET = 16'd66;

	localparam int IN_TDATA_W  = 7 * COORD_WIDTH;
	localparam int OUT_TDATA_W = 3 * COORD_WIDTH;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef logic [COORD_WIDTH-1:0] coord_t;
	typedef logic [DW-1:0] wide_t;

	// per-item data that rides along the divider
	typedef struct packed {
		logic               hit;
		logic               one;
		logic [2:0]         neg;
		logic [2:0][COORD_WIDTH-1:0] st;
		logic [2:0][DW-1:0] md;
	} side_t;

	typedef struct packed {
		side_t                  side;
		wide_t                  ad;
		wide_t                  r;
		logic [T_FRAC_BITS-1:0] q;
	} div_t;

	function automatic wide_t sext(input coord_t v);
		return {v[COORD_WIDTH-1], v};
	endfunction

	function automatic wide_t mag(input wide_t v);
		return v[DW-1] ? (~v + wide_t'(1)) : v;
	endfunction

endpackage

FILE: src/segment_axis_plane_intersect.sv
// Pipeline: 28 register stages (delta, test, 24 divider stages, multiply, add).
// Throughput: one item per cycle unless the output stalls; the 24-stage restoring
//   divider is fully pipelined.
// Reset (arst_n low, asynchronous): all stage valid bits clear, min_abs_delta
//   returns to 66; pipeline payload is not reset.
module segment_axis_plane_intersect (
	input  logic                             clk,
	input  logic                             arst_n,
	// config: min_abs_delta, Q16.0 unsigned, in coordinate LSBs
	input  logic                             cfg_we,
	input  logic [sapi_pkg::CFG_W-1:0]       cfg_wdata,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, plane_pos (lowest first)
	input  logic [sapi_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// opcode (plane axis)
	input  logic [1:0]                       s_axis_tuser,
	// output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// point_x, point_y, point_z (lowest first)
	output logic [sapi_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// hit
	output logic [0:0]                       m_axis_tuser
);
	import sapi_pkg::*;

	// threshold register
	logic [CFG_W-1:0] min_abs_delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_abs_delta_q <= MIN_DELTA_RESET;
		end else if (cfg_we) begin
			min_abs_delta_q <= cfg_wdata;
		end
	end

	// ---------------- handshake: each stage moves when it is empty or the next moves
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic div_in_ready, div_out_valid;
	div_t div_out;

	assign rdy_s4 = !vld_s4 || m_axis_tready;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || div_in_ready;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	// ---------------- stage 1: unpack, pick the plane axis, form differences
	logic [2:0][COORD_WIDTH-1:0] st_c, en_c;
	coord_t plane_c, sel_s_c, sel_e_c;
	logic   axis_ok_c;
	wide_t  delta_c, num_c;
	logic [2:0][DW-1:0] d_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			st_c[i] = s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
			en_c[i] = s_axis_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH];
			d_c[i]  = sext(en_c[i]) - sext(st_c[i]);
		end
		plane_c = s_axis_tdata[6*COORD_WIDTH +: COORD_WIDTH];
		axis_ok_c = 1'b1;
		sel_s_c   = st_c[0];
		sel_e_c   = en_c[0];
		case (s_axis_tuser)
			AXIS_X: begin
				sel_s_c = st_c[0];
				sel_e_c = en_c[0];
			end
			AXIS_Y: begin
				sel_s_c = st_c[1];
				sel_e_c = en_c[1];
			end
			AXIS_Z: begin
				sel_s_c = st_c[2];
				sel_e_c = en_c[2];
			end
			default: axis_ok_c = 1'b0;  // code 3: forced miss
		endcase
		delta_c = sext(sel_e_c) - sext(sel_s_c);
		num_c   = sext(plane_c) - sext(sel_s_c);
	end

	logic                         ok_s1;
	wide_t                        delta_s1, num_s1;
	logic [2:0][DW-1:0]           d_s1;
	logic [2:0][COORD_WIDTH-1:0]  st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			ok_s1    <= axis_ok_c;
			delta_s1 <= delta_c;
			num_s1   <= num_c;
			d_s1     <= d_c;
			st_s1    <= st_c;
		end
	end

	// ---------------- stage 2: magnitudes, parallel / range test, divider setup
	wide_t ad_c, an_c;
	logic  miss_c;
	div_t  div_in_c, div_in_s2;

	always_comb begin
		ad_c   = mag(delta_s1);
		an_c   = mag(num_s1);
		// t in [0,1]: num zero, or same sign as delta with |num| <= |delta|
		miss_c = !ok_s1
			|| (ad_c == '0)
			|| (ad_c < DW'(min_abs_delta_q))
			|| ((num_s1 != '0) && (num_s1[DW-1] != delta_s1[DW-1]))
			|| (an_c > ad_c);
		div_in_c.side.hit = !miss_c;
		div_in_c.side.one = (an_c == ad_c);
		div_in_c.side.st  = st_s1;
		for (int i = 0; i < 3; i++) begin
			div_in_c.side.neg[i] = d_s1[i][DW-1];
			div_in_c.side.md[i]  = mag(d_s1[i]);
		end
		div_in_c.ad = ad_c;
		div_in_c.r  = an_c;
		div_in_c.q  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			div_in_s2 <= div_in_c;
		end
	end

	// ---------------- divider: t = |num| / |delta|, one bit per stage
	sapi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (div_in_ready),
		.in_data   (div_in_s2),
		.out_valid (div_out_valid),
		.out_ready (rdy_s3),
		.out_data  (div_out)
	);

	// ---------------- stage 3: |d| * t on each axis, truncated
	logic [T_FRAC_BITS:0]  t_c;
	logic [PW-1:0]         prod_c [3];
	logic [2:0][DW-1:0]    term_c;

	always_comb begin
		// |num| == |delta| gives exactly 1.0
		t_c = div_out.side.one ? {1'b1, {T_FRAC_BITS{1'b0}}} : {1'b0, div_out.q};
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = PW'(div_out.side.md[i]) * PW'(t_c);
			term_c[i] = prod_c[i][T_FRAC_BITS +: DW];
		end
	end

	logic                        hit_s3;
	logic [2:0]                  neg_s3;
	logic [2:0][COORD_WIDTH-1:0] st_s3;
	logic [2:0][DW-1:0]          term_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && div_out_valid) begin
			hit_s3  <= div_out.side.hit;
			neg_s3  <= div_out.side.neg;
			st_s3   <= div_out.side.st;
			term_s3 <= term_c;
		end
	end

	// ---------------- stage 4: start +/- term, zero on miss; output register
	// result lies between start and end, so modular add never wraps
	logic [2:0][COORD_WIDTH-1:0] pt_c;
	logic [2:0][COORD_WIDTH-1:0] pt_s4;
	logic                        hit_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!hit_s3) begin
				pt_c[i] = '0;
			end else if (neg_s3[i]) begin
				pt_c[i] = st_s3[i] - term_s3[i][COORD_WIDTH-1:0];
			end else begin
				pt_c[i] = st_s3[i] + term_s3[i][COORD_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			hit_s4 <= hit_s3;
			pt_s4  <= pt_c;
		end
	end

	assign m_axis_tvalid   = vld_s4;
	assign m_axis_tdata    = pt_s4;
	assign m_axis_tuser[0] = hit_s4;

endmodule

FILE: src/sapi_div.sv
module sapi_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sapi_pkg::div_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sapi_pkg::div_t out_data
);
	import sapi_pkg::*;

	// restoring divider, one quotient bit per stage
	logic vld_s  [1:T_FRAC_BITS];
	div_t data_s [1:T_FRAC_BITS];

	logic cur_v [0:T_FRAC_BITS-1];
	div_t cur_d [0:T_FRAC_BITS-1];
	logic rdy   [0:T_FRAC_BITS-1];

	always_comb begin
		cur_v[0] = in_valid;
		cur_d[0] = in_data;
		for (int k = 1; k < T_FRAC_BITS; k++) begin
			cur_v[k] = vld_s[k];
			cur_d[k] = data_s[k];
		end
	end

	always_comb begin
		rdy[T_FRAC_BITS-1] = !vld_s[T_FRAC_BITS] || out_ready;
		for (int k = T_FRAC_BITS - 2; k >= 0; k--) begin
			rdy[k] = !vld_s[k+1] || rdy[k+1];
		end
	end

	for (genvar k = 0; k < T_FRAC_BITS; k++) begin : g_stage
		logic [DW:0] rs;
		logic [DW:0] diff;
		logic        ge;
		div_t        nxt;

		always_comb begin
			rs    = {cur_d[k].r, 1'b0};
			diff  = rs - {1'b0, cur_d[k].ad};
			ge    = rs >= {1'b0, cur_d[k].ad};
			nxt   = cur_d[k];
			nxt.r = ge ? diff[DW-1:0] : rs[DW-1:0];
			nxt.q = {cur_d[k].q[T_FRAC_BITS-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k+1] <= cur_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && cur_v[k]) begin
				data_s[k+1] <= nxt;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[T_FRAC_BITS];
	assign out_data  = data_s[T_FRAC_BITS];

endmodule

FILE: src/sapi_checker.sv
`include "segment_axis_plane_intersect_macros.svh"

module sapi_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [sapi_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]                       m_axis_tuser
);

	// held result keeps valid and payload
	`SAPI_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")

	// a miss reports the origin on every axis
	`SAPI_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "miss with nonzero point")

	// with the output free no stage can hold back the input
	`SAPI_ASSERT_NOW(a_no_bubble_stall, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled while output is free")

endmodule

bind segment_axis_plane_intersect sapi_checker u_sapi_checker (.*);
